// ===== design/tlpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

  // Address split: directory index, table index, page offset.
  localparam int IDX_W         = 10;
  localparam int OFS_W         = 12;
  localparam int VA_W          = 32;
  localparam int FRAME_W       = 20;
  localparam int FLAGS_W       = 12;
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int LIMIT_W       = 5;

  // Default pool size and reset value of the table limit register.
  localparam int           POOL_TABLES_DEF = 16;
  localparam logic [4:0]   LIMIT_RESET     = 5'd16;

  // Entry flag bit positions.
  localparam int FLAG_PRESENT = 0;
  localparam int FLAG_RW      = 1;
  localparam int FLAG_USER    = 2;
  localparam int DIR_FLAGS_W  = 3;

  // Output word layout, lowest bit up.
  localparam int OUT_FIELDS_W = 1 + 1 + VA_W + 1;
  localparam int OUT_TDATA_W  = 40;
  localparam int IN_TDATA_W   = VA_W + FRAME_W + FLAGS_W;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_MAP_USER  = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_TRANSLATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_CLEAR,
    S_TBL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/two_level_page_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Word contents (lowest bit up)
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: virt_addr, phys_frame, entry_flags
// m_*       out  m_tvalid/m_tready  tdata: status, mapped, phys_addr, tlb_invalidate, zeros
// cfg_*     in   cfg_we             cfg_wdata: table_limit
//
// Each item is accepted in S_IDLE with its directory read, then passes S_DIR and S_DONE;
// a translate through a present directory entry adds S_TBL between S_DIR and S_DONE.
// Each item does a directory read, then at most one table read or write; a map that
// allocates a table instead writes the directory and sweeps the new table clear in S_CLEAR.
// After reset the directory is cleared before the first word is taken.
// A finished result waits in the output register while the next word is accepted.
module two_level_page_table_engine
  import tlpt_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  input  wire logic [1:0]             s_tuser,   // opcode
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // virt_addr, phys_frame, entry_flags
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  output      logic [OUT_TDATA_W-1:0] m_tdata,   // status, mapped, phys_addr, tlb_invalidate
  input  wire logic                   cfg_we,
  input  wire logic [LIMIT_W-1:0]     cfg_wdata  // table_limit
);

  localparam int TBL_W   = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CNT_W   = $clog2(POOL_TABLES + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int DIR_W   = DIR_FLAGS_W + TBL_W;
  localparam int TDEPTH  = POOL_TABLES * TABLE_ENTRIES;
  localparam int TA_W    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int DA_W    = $clog2(DIR_ENTRIES);

  state_t state, state_next;

  logic [LIMIT_W-1:0] table_limit;
  logic [CNT_W-1:0]   tables_used;
  logic [IDX_W-1:0]   sweep;
  logic [TBL_W-1:0]   cur_tbl;

  op_t                op;
  logic [VA_W-1:0]    va;
  logic [FRAME_W-1:0] frame;
  logic [FLAGS_W-1:0] flags;

  logic               res_status;
  logic               res_mapped;
  logic [VA_W-1:0]    res_pa;
  logic               res_tlb;

  logic               dir_en, dir_we;
  logic [DA_W-1:0]    dir_addr;
  logic [DIR_W-1:0]   dir_wdata, dir_rdata;
  logic               tbl_en, tbl_we;
  logic [TA_W-1:0]    tbl_addr;
  logic [31:0]        tbl_wdata, tbl_rdata;

  logic               s_accept, out_load;
  logic               is_map, de_present, pool_full, alloc, sweep_last;
  logic [TBL_W-1:0]   de_tbl, new_tbl;
  logic [IDX_W-1:0]   pd, pt;
  logic [31:0]        entry_word;
  logic [FLAGS_W-1:0] user_mask;

  tlpt_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .en    (dir_en),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_tbl_ram (
    .clk   (clk),
    .en    (tbl_en),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  // Decode of the held word and the directory read.
  always_comb begin
    pd         = va[VA_W-1 -: IDX_W];
    pt         = va[OFS_W +: IDX_W];
    is_map     = (op == OP_MAP) || (op == OP_MAP_USER);
    de_present = dir_rdata[FLAG_PRESENT];
    de_tbl     = dir_rdata[DIR_FLAGS_W +: TBL_W];
    new_tbl    = TBL_W'(tables_used);
    pool_full  = (CMP_W'(tables_used) >= CMP_W'(table_limit)) ||
                 (tables_used == CNT_W'(POOL_TABLES));
    alloc      = is_map && !de_present && !pool_full;
    user_mask  = '0;
    user_mask[FLAG_USER] = (op == OP_MAP_USER);
    entry_word = {frame, flags | user_mask};
    sweep_last = (sweep == IDX_W'(DIR_ENTRIES - 1));
    s_accept   = s_tvalid && s_tready;
    out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DIR;
      end
      S_DIR: begin
        if (alloc) begin
          state_next = S_CLEAR;
        end else if ((op == OP_TRANSLATE) && de_present) begin
          state_next = S_TBL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        if (sweep_last) state_next = S_DONE;
      end
      S_TBL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    s_tready  = (state == S_IDLE);
    dir_en    = 1'b0;
    dir_we    = 1'b0;
    dir_addr  = pd;
    dir_wdata = '0;
    tbl_en    = 1'b0;
    tbl_we    = 1'b0;
    tbl_addr  = TA_W'({de_tbl, pt});
    tbl_wdata = '0;
    unique case (state)
      S_INIT: begin
        dir_en   = 1'b1;
        dir_we   = 1'b1;
        dir_addr = sweep;
      end
      S_IDLE: begin
        dir_en   = s_tvalid;
        dir_addr = s_tdata[VA_W-1 -: IDX_W];
      end
      S_DIR: begin
        if (alloc) begin
          dir_en    = 1'b1;
          dir_we    = 1'b1;
          dir_wdata = {new_tbl, (op == OP_MAP_USER), 1'b1, 1'b1};
        end else if (de_present) begin
          tbl_en    = 1'b1;
          tbl_we    = (op != OP_TRANSLATE);
          tbl_wdata = is_map ? entry_word : 32'd0;
        end
      end
      S_CLEAR: begin
        // The mapped entry is written in its own slot of the clearing sweep.
        tbl_en    = 1'b1;
        tbl_we    = 1'b1;
        tbl_addr  = TA_W'({cur_tbl, sweep});
        tbl_wdata = (sweep == pt) ? entry_word : 32'd0;
      end
      S_TBL, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      tables_used <= '0;
      table_limit <= LIMIT_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) table_limit <= cfg_wdata;
      if ((state == S_INIT) || (state == S_CLEAR)) begin
        sweep <= sweep + 1'b1;
      end else if (state == S_DIR) begin
        sweep <= '0;
      end
      if ((state == S_DIR) && alloc) tables_used <= tables_used + 1'b1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Held word, result and output registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op    <= op_t'(s_tuser);
      va    <= s_tdata[VA_W-1:0];
      frame <= s_tdata[VA_W +: FRAME_W];
      flags <= s_tdata[VA_W + FRAME_W +: FLAGS_W];
    end
    if (state == S_DIR) begin
      cur_tbl    <= new_tbl;
      res_status <= is_map && !de_present && pool_full;
      res_tlb    <= (is_map && (de_present || !pool_full)) ||
                    ((op == OP_UNMAP) && de_present);
      res_mapped <= 1'b0;
      res_pa     <= '0;
    end
    if (state == S_TBL) begin
      res_mapped <= tbl_rdata[FLAG_PRESENT];
      res_pa     <= tbl_rdata[FLAG_PRESENT] ? {tbl_rdata[31:OFS_W], va[OFS_W-1:0]} : '0;
    end
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res_tlb, res_pa, res_mapped,
                  res_status};
    end
  end

endmodule

`default_nettype wire

// ===== design/tlpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port synchronous RAM with a registered read.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // When enabled, write if we is set, otherwise read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire
